@@ rtl/core/smc_pkg.sv @@
// Shared types, constants and element tables of the structured mesh connectivity block.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none
package smc_pkg;

	localparam int unsigned MAX_CELLS_DEF = 1024;
	localparam int unsigned QUEUE_DEPTH   = 8;
	localparam int unsigned CFG_SETTLE    = 3;

	localparam logic [1:0] CFG_KIND = 2'd0;
	localparam logic [1:0] CFG_NX   = 2'd1;
	localparam logic [1:0] CFG_NY   = 2'd2;
	localparam logic [1:0] CFG_NZ   = 2'd3;

	typedef enum logic [2:0] {
		EK_POINT   = 3'd0,
		EK_LINE    = 3'd1,
		EK_TRI     = 3'd2,
		EK_QUAD    = 3'd3,
		EK_HEX     = 3'd4,
		EK_TET     = 3'd5,
		EK_PRISM   = 3'd6,
		EK_PYRAMID = 3'd7
	} elem_kind_t;

	// Index of the added cell centre in the id set.
	localparam logic [3:0] CENTRE = 4'd8;

	typedef struct packed {
		elem_kind_t  kind;
		logic [10:0] nx;
		logic [10:0] ny;
		logic [10:0] nz;
		logic [10:0] row;
		logic [20:0] plane;
		logic [31:0] total;
	} cfg_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] centre;
		logic        odd;
		logic        bad;
	} qentry_t;

	typedef logic [7:0][3:0] pick_t;

	function automatic pick_t mk(input logic [3:0] a, input logic [3:0] b, input logic [3:0] c,
			input logic [3:0] d, input logic [3:0] e, input logic [3:0] f,
			input logic [3:0] g, input logic [3:0] h);
		pick_t p;
		p[0] = a; p[1] = b; p[2] = c; p[3] = d;
		p[4] = e; p[5] = f; p[6] = g; p[7] = h;
		return p;
	endfunction

	function automatic logic [2:0] elem_count(input elem_kind_t kind);
		logic [2:0] n;
		unique case (kind)
			EK_POINT:   n = 3'd1;
			EK_LINE:    n = 3'd3;
			EK_TRI:     n = 3'd2;
			EK_QUAD:    n = 3'd1;
			EK_HEX:     n = 3'd1;
			EK_TET:     n = 3'd5;
			EK_PRISM:   n = 3'd2;
			EK_PYRAMID: n = 3'd6;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] vert_count(input elem_kind_t kind);
		logic [3:0] n;
		unique case (kind)
			EK_POINT:   n = 4'd1;
			EK_LINE:    n = 4'd2;
			EK_TRI:     n = 4'd3;
			EK_QUAD:    n = 4'd4;
			EK_HEX:     n = 4'd8;
			EK_TET:     n = 4'd4;
			EK_PRISM:   n = 4'd6;
			EK_PYRAMID: n = 4'd5;
		endcase
		return n;
	endfunction

	// Corner indices of element e; slots beyond the vertex count are don't-care.
	function automatic pick_t elem_pick(input elem_kind_t kind, input logic odd,
			input logic [2:0] e);
		pick_t p;
		p = mk(4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7);
		unique case (kind)
			EK_LINE: begin
				priority case (e)
					3'd0:    p = mk(4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
					3'd1:    p = mk(4'd0, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
					default: p = mk(4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
				endcase
			end
			EK_TRI: begin
				if (odd) begin
					p = (e == 3'd0) ? mk(4'd0, 4'd1, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0)
					                : mk(4'd0, 4'd2, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
				end else begin
					p = (e == 3'd0) ? mk(4'd0, 4'd1, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0)
					                : mk(4'd1, 4'd2, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
				end
			end
			EK_TET: begin
				priority case (e)
					3'd0:    p = mk(4'd0, 4'd1, 4'd2, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0);
					3'd1:    p = mk(4'd0, 4'd2, 4'd3, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0);
					3'd2:    p = mk(4'd0, 4'd5, 4'd7, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0);
					3'd3:    p = mk(4'd2, 4'd7, 4'd5, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0);
					default: p = mk(4'd0, 4'd5, 4'd2, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0);
				endcase
			end
			EK_PRISM: begin
				p = (e == 3'd0) ? mk(4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd7, 4'd0, 4'd0)
				                : mk(4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd0, 4'd0);
			end
			EK_PYRAMID: begin
				priority case (e)
					3'd0:    p = mk(4'd0, 4'd1, 4'd2, 4'd3, CENTRE, 4'd0, 4'd0, 4'd0);
					3'd1:    p = mk(4'd0, 4'd4, 4'd5, 4'd1, CENTRE, 4'd0, 4'd0, 4'd0);
					3'd2:    p = mk(4'd1, 4'd5, 4'd6, 4'd2, CENTRE, 4'd0, 4'd0, 4'd0);
					3'd3:    p = mk(4'd2, 4'd6, 4'd7, 4'd3, CENTRE, 4'd0, 4'd0, 4'd0);
					3'd4:    p = mk(4'd0, 4'd3, 4'd7, 4'd4, CENTRE, 4'd0, 4'd0, 4'd0);
					default: p = mk(4'd4, 4'd7, 4'd6, 4'd5, CENTRE, 4'd0, 4'd0, 4'd0);
				endcase
			end
			EK_POINT, EK_QUAD, EK_HEX: begin
				p = mk(4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7);
			end
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/smc_front.sv @@
// Front pipeline: range check and base / centre vertex id arithmetic for one cell.
// Depends on smc_pkg.
`default_nettype none
module smc_front
	import smc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	input  wire logic [10:0] cell_x,
	input  wire logic [10:0] cell_y,
	input  wire logic [10:0] cell_z,
	output logic             out_valid,
	output qentry_t          out_entry
);

	logic        volume;
	logic [10:0] z_eff;
	logic        bad;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [10:0] x_s1, x_s2, x_s3;
	logic [10:0] y_s1;
	logic [21:0] yrow_s1;
	logic [31:0] zpl_s1;
	logic [21:0] zny_s1;
	logic        bad_s1, bad_s2, bad_s3, bad_s4;
	logic        odd_s1, odd_s2, odd_s3, odd_s4;
	logic [31:0] base_s2, base_s3, base_s4;
	logic [22:0] t_s2;
	logic [31:0] cm_s3;
	logic [31:0] centre_s4;

	assign volume = cfg.kind[2];
	assign z_eff  = volume ? cell_z : 11'd0;

	always_comb begin
		if (cfg.kind == EK_POINT) begin
			bad = (cell_x > cfg.nx) || (cell_y > cfg.ny);
		end else begin
			bad = (cell_x >= cfg.nx) || (cell_y >= cfg.ny) || (volume && (cell_z >= cfg.nz));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: the three products of the id formulae.
	always_ff @(posedge clk) begin
		x_s1    <= cell_x;
		y_s1    <= cell_y;
		yrow_s1 <= 22'(cell_y) * 22'(cfg.row);
		zpl_s1  <= 32'(z_eff) * 32'(cfg.plane);
		zny_s1  <= 22'(z_eff) * 22'(cfg.ny);
		bad_s1  <= bad;
		// Parity of y*NX + x needs only the low bits.
		odd_s1  <= (cell_y[0] & cfg.nx[0]) ^ cell_x[0];
	end

	// Stage 2: corner-0 id and the start of the centre index.
	always_ff @(posedge clk) begin
		base_s2 <= zpl_s1 + 32'(yrow_s1) + 32'(x_s1);
		t_s2    <= 23'(zny_s1) + 23'(y_s1);
		x_s2    <= x_s1;
		bad_s2  <= bad_s1;
		odd_s2  <= odd_s1;
	end

	always_ff @(posedge clk) begin
		cm_s3   <= 32'(t_s2) * 32'(cfg.nx);
		base_s3 <= base_s2;
		x_s3    <= x_s2;
		bad_s3  <= bad_s2;
		odd_s3  <= odd_s2;
	end

	always_ff @(posedge clk) begin
		centre_s4 <= cfg.total + cm_s3 + 32'(x_s3);
		base_s4   <= base_s3;
		bad_s4    <= bad_s3;
		odd_s4    <= odd_s3;
	end

	assign out_valid        = v_s4;
	assign out_entry.base   = base_s4;
	assign out_entry.centre = centre_s4;
	assign out_entry.odd    = odd_s4;
	assign out_entry.bad    = bad_s4;

endmodule
`default_nettype wire

@@ rtl/core/smc_queue.sv @@
// Short register FIFO that decouples the front pipeline from the element emitter.
// Depends on smc_pkg.
`default_nettype none
module smc_queue
	import smc_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire qentry_t push_entry,
	input  wire logic    pop,
	output logic         head_valid,
	output qentry_t      head_entry
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	qentry_t         store [DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign head_valid = (count_q != '0);
	assign head_entry = store[rptr_q];

endmodule
`default_nettype wire

@@ rtl/core/smc_back.sv @@
// Element emitter: queued cells to elements, one result per cycle unless stalled.
// Depends on smc_pkg.
`default_nettype none
module smc_back
	import smc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire logic    head_valid,
	input  wire qentry_t head_entry,
	output logic         pop,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output logic [263:0] m_tdata,
	output logic         m_tuser,
	output logic         m_tlast
);

	logic [2:0]       elem_q;
	logic             out_valid_q;
	logic [7:0][31:0] verts_q;
	logic [3:0]       used_q;
	logic             bad_q, last_q;

	logic [31:0]      ids [9];
	logic [31:0]      bp;
	pick_t            pick;
	logic [3:0]       nv;
	logic             advance, fire, last;
	logic [7:0][31:0] verts_d;

	assign bp = head_entry.base + 32'(cfg.plane);

	always_comb begin
		ids[0] = head_entry.base;
		ids[1] = head_entry.base + 32'd1;
		ids[2] = head_entry.base + 32'(cfg.row) + 32'd1;
		ids[3] = head_entry.base + 32'(cfg.row);
		ids[4] = bp;
		ids[5] = bp + 32'd1;
		ids[6] = bp + 32'(cfg.row) + 32'd1;
		ids[7] = bp + 32'(cfg.row);
		ids[8] = head_entry.centre;
	end

	assign pick    = elem_pick(cfg.kind, head_entry.odd, elem_q);
	assign nv      = vert_count(cfg.kind);
	assign advance = !out_valid_q || m_tready;
	assign fire    = head_valid && advance;
	assign last    = head_entry.bad || (elem_q == elem_count(cfg.kind) - 3'd1);
	assign pop     = fire && last;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			verts_d[i] = (!head_entry.bad && (4'(i) < nv)) ? ids[pick[i]] : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				elem_q <= last ? 3'd0 : elem_q + 3'd1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			verts_q <= verts_d;
			used_q  <= head_entry.bad ? 4'd0 : nv;
			bad_q   <= head_entry.bad;
			last_q  <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, used_q, verts_q};
	assign m_tuser  = bad_q;
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

@@ rtl/core/structured_mesh_connectivity.sv @@
// Top level of the structured mesh connectivity block: configuration registers and glue.
// Depends on smc_pkg, smc_front, smc_queue and smc_back.
//
// Takes one cell coordinate per request and returns one result per element of that cell
// (one flagged result for a bad cell), at one result per cycle from the emitter while
// m_tready is high. A request in point, quad or hex mode yields one result, line three,
// tri and prism two, tet five and pyramid six, so the emitter, which gives one result at
// a time, limits the sustained input rate. The first result of a request passes through
// a four-stage id pipeline and an eight-entry queue, and requests are taken while results
// still wait. After any configuration write the input is held off by the settle counter
// while the derived plane and total sizes are recomputed. Cell counts above MAX_CELLS are
// saturated on write.
`default_nettype none
module structured_mesh_connectivity
	import smc_pkg::*;
#(
	parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [10:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,  // cell_x, cell_y, cell_z, zero pad
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [263:0]      m_tdata,  // vert_a .. vert_h, verts_used, zero pad
	output logic              m_tuser,  // bad_cell
	output logic              m_tlast
);

	localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

	elem_kind_t  kind_q;
	logic [10:0] nx_q, ny_q, nz_q;
	logic [20:0] plane_q;
	logic [31:0] total_q;
	logic [1:0]  settle_q;
	logic [OCC_W-1:0] occ_q;
	logic [10:0] wclamp;

	cfg_t    cfg;
	logic    accept;
	logic    f_valid;
	qentry_t f_entry;
	logic    head_valid;
	qentry_t head_entry;
	logic    pop;

	assign wclamp = (32'(cfg_wdata) > MAX_CELLS) ? 11'(MAX_CELLS) : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= EK_HEX;
			nx_q     <= 11'd11;
			ny_q     <= 11'd12;
			nz_q     <= 11'd6;
			settle_q <= 2'(CFG_SETTLE);
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_KIND: kind_q <= elem_kind_t'(cfg_wdata[2:0]);
					CFG_NX:   nx_q   <= wclamp;
					CFG_NY:   ny_q   <= wclamp;
					CFG_NZ:   nz_q   <= wclamp;
				endcase
				settle_q <= 2'(CFG_SETTLE);
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// Derived sizes are registered: the plane size from the cell counts, and the total from the registered plane size.
	always_ff @(posedge clk) begin
		plane_q <= (21'(nx_q) + 21'd1) * (21'(ny_q) + 21'd1);
		total_q <= 32'(plane_q) * (32'(nz_q) + 32'd1);
	end

	assign cfg.kind  = kind_q;
	assign cfg.nx    = nx_q;
	assign cfg.ny    = ny_q;
	assign cfg.nz    = nz_q;
	assign cfg.row   = nx_q + 11'd1;
	assign cfg.plane = plane_q;
	assign cfg.total = total_q;

	// Occupancy covers the pipeline and the queue, so the queue can never overflow.
	assign s_tready = (occ_q < OCC_W'(QUEUE_DEPTH)) && (settle_q == 2'd0);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(accept) - OCC_W'(pop);
		end
	end

	smc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (accept),
		.cell_x    (s_tdata[10:0]),
		.cell_y    (s_tdata[21:11]),
		.cell_z    (s_tdata[32:22]),
		.out_valid (f_valid),
		.out_entry (f_entry)
	);

	smc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (f_valid),
		.push_entry (f_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	smc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire
